@@ rtl/csb_pkg.sv @@
// Shared types and constants for the clipped alpha sprite blit unit.
// Depends on nothing; every other file in rtl/ imports it.
package csb_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int POS_W       = 12;
    localparam int SPR_REG_W   = 11;
    localparam int SCR_REG_W   = 12;
    localparam int CHAN_W      = 8;
    localparam int INDEX_W     = 22;
    localparam int QDEPTH      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

    // Colors of one texel and the backdrop under it.
    typedef struct packed {
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] src_alpha;
        logic [CHAN_W-1:0] back_blue;
        logic [CHAN_W-1:0] back_green;
        logic [CHAN_W-1:0] back_red;
    } t_pix;

    // Raw configuration registers.
    typedef struct packed {
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [SPR_REG_W-1:0] sprite_width;
        logic [SPR_REG_W-1:0] sprite_height;
        logic [SCR_REG_W-1:0] screen_width;
        logic [SCR_REG_W-1:0] screen_height;
    } t_cfg;

endpackage

@@ rtl/csb_front.sv @@
// Front end: raster counters, placement and clip test for each texel.
// Depends on csb_pkg; feeds csb_queue.
module csb_front #(
    parameter int MAX_SPRITE_DIM = 1024,
    parameter int SDW            = 12,
    parameter int XW             = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_room,
    input  csb_pkg::t_cfg          i_cfg,
    input  logic [SDW-1:0]         i_scw,
    input  logic [SDW-1:0]         i_sch,
    output logic                   o_push,
    output logic [XW-1:0]          o_x,
    output logic [XW-1:0]          o_y,
    output logic                   o_vis,
    output logic                   o_last
);
    import csb_pkg::*;

    localparam int CW  = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;
    localparam int SPW = $clog2(MAX_SPRITE_DIM + 1);
    localparam int CRW = ((CW > POS_W) ? CW : POS_W) + 2;

    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_row, n_row;
    logic [SPW-1:0] sw, sh;
    logic signed [CRW-1:0] x, y;
    logic           row_end;

    always_comb begin
        if (i_cfg.sprite_width == '0) begin
            sw = SPW'(1);
        end else if (32'(i_cfg.sprite_width) > MAX_SPRITE_DIM) begin
            sw = SPW'(MAX_SPRITE_DIM);
        end else begin
            sw = SPW'(i_cfg.sprite_width);
        end
        if (i_cfg.sprite_height == '0) begin
            sh = SPW'(1);
        end else if (32'(i_cfg.sprite_height) > MAX_SPRITE_DIM) begin
            sh = SPW'(MAX_SPRITE_DIM);
        end else begin
            sh = SPW'(i_cfg.sprite_height);
        end
    end

    assign x = $signed({{(CRW-POS_W){i_cfg.pos_x[POS_W-1]}}, i_cfg.pos_x})
             + $signed({{(CRW-CW){1'b0}}, r_col});
    assign y = $signed({{(CRW-POS_W){i_cfg.pos_y[POS_W-1]}}, i_cfg.pos_y})
             + $signed({{(CRW-CW){1'b0}}, r_row});

    assign o_vis = !x[CRW-1] && !y[CRW-1]
                 && (x[CRW-2:0] < (CRW-1)'(i_scw))
                 && (y[CRW-2:0] < (CRW-1)'(i_sch));
    // Coordinates only matter when visible, so they fit below the screen size.
    assign o_x = x[XW-1:0];
    assign o_y = y[XW-1:0];

    assign row_end = ((SPW+1)'(r_col) + (SPW+1)'(1)) >= (SPW+1)'(sw);
    assign o_last  = row_end && (((SPW+1)'(r_row) + (SPW+1)'(1)) >= (SPW+1)'(sh));
    assign o_push  = i_valid && i_room;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (!row_end) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                n_row = o_last ? '0 : r_row + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ rtl/csb_queue.sv @@
// Small FIFO between the classifying front end and the blend back end.
// Depends on csb_pkg for its depth.
module csb_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_room,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    import csb_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);

    logic [W-1:0]  r_mem [QDEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_room  = (r_cnt != NW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/csb_back.sv @@
// Back end: two-stage blend and pixel index pipeline with output register.
// Depends on csb_pkg; drains csb_queue.
module csb_back #(
    parameter int SDW = 12,
    parameter int XW  = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  csb_pkg::t_pix                i_pix,
    input  logic [XW-1:0]                i_x,
    input  logic [XW-1:0]                i_y,
    input  logic                         i_vis,
    input  logic                         i_last,
    input  logic [SDW-1:0]               i_scw,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [csb_pkg::CHAN_W-1:0]   o_blue,
    output logic [csb_pkg::CHAN_W-1:0]   o_green,
    output logic [csb_pkg::CHAN_W-1:0]   o_red,
    output logic [csb_pkg::INDEX_W-1:0]  o_index,
    output logic                         o_vis,
    output logic                         o_last
);
    import csb_pkg::*;

    localparam int MW = 2 * CHAN_W;
    localparam int PW = XW + SDW;
    localparam int EW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;

    // x/255 for x up to 255*255, exact.
    function automatic logic [CHAN_W-1:0] div255(input logic [MW:0] n);
        logic [MW:0] t;
        t = n + (MW+1)'(1) + (n >> CHAN_W);
        return t[MW-1:CHAN_W];
    endfunction

    // Stage one: products.
    logic              r_v1;
    logic [MW-1:0]     r_sb, r_db, r_sg, r_dg, r_sr, r_dr;
    logic [PW-1:0]     r_prod;
    logic [XW-1:0]     r_x;
    logic              r_vis1, r_last1;
    logic [CHAN_W-1:0] inv_a;
    logic              adv1, adv2;
    logic [EW-1:0]     sum_idx;

    // Stage two: output register.
    logic              r_v2;

    assign adv2  = !r_v2 || i_ready;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = i_valid && adv1;
    assign inv_a = ~i_pix.src_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sb    <= i_pix.src_alpha * i_pix.src_blue;
            r_db    <= inv_a * i_pix.back_blue;
            r_sg    <= i_pix.src_alpha * i_pix.src_green;
            r_dg    <= inv_a * i_pix.back_green;
            r_sr    <= i_pix.src_alpha * i_pix.src_red;
            r_dr    <= inv_a * i_pix.back_red;
            r_prod  <= PW'(i_y) * PW'(i_scw);
            r_x     <= i_x;
            r_vis1  <= i_vis;
            r_last1 <= i_last;
        end
    end

    assign sum_idx = EW'(r_prod) + EW'(r_x);

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            o_blue  <= div255((MW+1)'(r_sb) + (MW+1)'(r_db));
            o_green <= div255((MW+1)'(r_sg) + (MW+1)'(r_dg));
            o_red   <= div255((MW+1)'(r_sr) + (MW+1)'(r_dr));
            o_index <= r_vis1 ? sum_idx[INDEX_W-1:0] : '0;
            o_vis   <= r_vis1;
            o_last  <= r_last1;
        end
    end

    assign o_valid = r_v2;

endmodule

@@ rtl/clipped_alpha_sprite_blit_unit.sv @@
// Clipped alpha sprite blit: one texel in, one blended, placed pixel out.
// An accepted item lands in the queue, then passes the product stage and then
// the blend/index output register. Throughput: one item per cycle while the
// output is not stalled by i_ready, set by the single 2-entry queue and the
// two-stage back-end pipeline.
// Reset (synchronous, active low): counters to the top left texel, queue and
// pipeline empty, pos_x/pos_y 0, all sizes 1.
module clipped_alpha_sprite_blit_unit #(
    parameter int MAX_SPRITE_DIM = 1024,
    parameter int MAX_SCREEN_DIM = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [csb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // texel input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [csb_pkg::CHAN_W-1:0]        i_src_blue,
    input  logic [csb_pkg::CHAN_W-1:0]        i_src_green,
    input  logic [csb_pkg::CHAN_W-1:0]        i_src_red,
    input  logic [csb_pkg::CHAN_W-1:0]        i_src_alpha,
    input  logic [csb_pkg::CHAN_W-1:0]        i_back_blue,
    input  logic [csb_pkg::CHAN_W-1:0]        i_back_green,
    input  logic [csb_pkg::CHAN_W-1:0]        i_back_red,
    // pixel output channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [csb_pkg::CHAN_W-1:0]        o_out_blue,
    output logic [csb_pkg::CHAN_W-1:0]        o_out_green,
    output logic [csb_pkg::CHAN_W-1:0]        o_out_red,
    output logic [csb_pkg::INDEX_W-1:0]       o_pixel_index,
    output logic                              o_visible,
    output logic                              o_last
);
    import csb_pkg::*;

    // Clamped screen size needs to hold MAX_SCREEN_DIM itself; a visible
    // coordinate stays below it.
    localparam int SDW = $clog2(MAX_SCREEN_DIM + 1);
    localparam int XW  = (MAX_SCREEN_DIM > 1) ? $clog2(MAX_SCREEN_DIM) : 1;
    localparam int QW  = $bits(t_pix) + 2 * XW + 2;

    t_cfg           r_cfg;
    logic [SDW-1:0] scw, sch;

    // Configuration registers; writes never touch the raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x         <= '0;
            r_cfg.pos_y         <= '0;
            r_cfg.sprite_width  <= SPR_REG_W'(1);
            r_cfg.sprite_height <= SPR_REG_W'(1);
            r_cfg.screen_width  <= SCR_REG_W'(1);
            r_cfg.screen_height <= SCR_REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POS_X:         r_cfg.pos_x         <= i_cfg_data[POS_W-1:0];
                REG_POS_Y:         r_cfg.pos_y         <= i_cfg_data[POS_W-1:0];
                REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[SPR_REG_W-1:0];
                REG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[SPR_REG_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[SCR_REG_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[SCR_REG_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Limit screen size to the largest supported screen; zero stays zero,
    // which hides every texel.
    always_comb begin
        if (32'(r_cfg.screen_width) > MAX_SCREEN_DIM) begin
            scw = SDW'(MAX_SCREEN_DIM);
        end else begin
            scw = SDW'(r_cfg.screen_width);
        end
        if (32'(r_cfg.screen_height) > MAX_SCREEN_DIM) begin
            sch = SDW'(MAX_SCREEN_DIM);
        end else begin
            sch = SDW'(r_cfg.screen_height);
        end
    end

    // Front end: place and classify each accepted texel.
    t_pix          in_pix;
    logic          q_room, push;
    logic [XW-1:0] f_x, f_y;
    logic          f_vis, f_last;

    assign in_pix = '{src_blue:   i_src_blue,
                      src_green:  i_src_green,
                      src_red:    i_src_red,
                      src_alpha:  i_src_alpha,
                      back_blue:  i_back_blue,
                      back_green: i_back_green,
                      back_red:   i_back_red};

    // Accept whenever the queue has room, even while a result waits.
    assign o_ready = q_room;

    csb_front #(
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
        .SDW            (SDW),
        .XW             (XW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_room  (q_room),
        .i_cfg   (r_cfg),
        .i_scw   (scw),
        .i_sch   (sch),
        .o_push  (push),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_vis   (f_vis),
        .o_last  (f_last)
    );

    // Queue decouples the classify step from the blend pipeline.
    logic [QW-1:0] q_in, q_out;
    logic          q_valid, q_pop;
    t_pix          b_pix;
    logic [XW-1:0] b_x, b_y;
    logic          b_vis, b_last;

    assign q_in = {in_pix, f_x, f_y, f_vis, f_last};
    assign {b_pix, b_x, b_y, b_vis, b_last} = q_out;

    csb_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_room  (q_room),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    // Back end: blend the three channels and form the destination index.
    csb_back #(
        .SDW (SDW),
        .XW  (XW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_pix   (b_pix),
        .i_x     (b_x),
        .i_y     (b_y),
        .i_vis   (b_vis),
        .i_last  (b_last),
        .i_scw   (scw),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_blue  (o_out_blue),
        .o_green (o_out_green),
        .o_red   (o_out_red),
        .o_index (o_pixel_index),
        .o_vis   (o_visible),
        .o_last  (o_last)
    );

endmodule
